// File: src/tbs_pkg.sv
// Shared types, constants and helpers for the trailing blank stripper.
package tbs_pkg;

  localparam int unsigned MAX_PENDING = 63;
  localparam int unsigned PTR_W = $clog2(MAX_PENDING);
  localparam int unsigned CNT_W = $clog2(MAX_PENDING + 1);

  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;

  localparam logic ACT_DATA = 1'b0;
  localparam logic ACT_EOS  = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } tbs_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } tbs_out_t;

  typedef enum logic [1:0] {
    CMD_BLANK,
    CMD_EOL,
    CMD_DATA,
    CMD_EOS
  } tbs_kind_t;

  typedef struct packed {
    tbs_kind_t  kind;
    logic [7:0] data_byte;
  } tbs_cmd_t;

  // circular store index: (ptr + off) mod MAX_PENDING, both operands in range
  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] ptr,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(ptr) + (CNT_W + 1)'(off);
    if (sum >= (CNT_W + 1)'(MAX_PENDING)) begin
      sum = sum - (CNT_W + 1)'(MAX_PENDING);
    end
    return PTR_W'(sum);
  endfunction

endpackage

// File: src/tbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tbs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: src/tbs_front.sv
// Input side: classifies each beat and queues the resulting command.
module tbs_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  tbs_pkg::tbs_in_t in_data,
  output logic             cmd_valid,
  output tbs_pkg::tbs_cmd_t cmd,
  input  logic             cmd_pop
);
  import tbs_pkg::*;

  tbs_cmd_t   q_r [2];
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  tbs_cmd_t   cls;
  logic       push;

  always_comb begin
    cls.data_byte = in_data.data_byte;
    priority if (in_data.action == ACT_EOS) begin
      cls.kind = CMD_EOS;
    end else if (in_data.data_byte == CH_SP || in_data.data_byte == CH_TAB) begin
      cls.kind = CMD_BLANK;
    end else if (in_data.data_byte == CH_CR || in_data.data_byte == CH_LF) begin
      cls.kind = CMD_EOL;
    end else begin
      cls.kind = CMD_DATA;
    end
  end

  assign in_stall  = (cnt_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_r];

  always_comb begin
    wr_nxt  = push ? !wr_r : wr_r;
    rd_nxt  = cmd_pop ? !rd_r : rd_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(cmd_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= cls;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2) else $error("command queue over capacity");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cnt_r != 2'd0) else $error("pop from empty command queue");
  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !cmd_pop) |=> cnt_r == 2'd2) else $error("full queue lost entry");

endmodule

// File: src/tbs_back.sv
// Output side: owns the blank store and emits result beats per command.
module tbs_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  input  tbs_pkg::tbs_cmd_t cmd,
  output logic              cmd_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output tbs_pkg::tbs_out_t out_data
);
  import tbs_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EMIT,
    S_FINAL,
    S_EVICT
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] ptr_r, ptr_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [7:0]       hold_r, hold_nxt;
  logic             out_valid_r, out_valid_nxt;
  tbs_out_t         out_r, out_nxt;

  logic             free;
  logic             emit;
  tbs_out_t         emit_item;
  logic             wr_en;
  logic [PTR_W-1:0] wr_addr;
  logic [7:0]       wr_data;
  logic             rd_en;
  logic [PTR_W-1:0] rd_addr;
  logic [7:0]       rd_data;

  tbs_ram #(.WIDTH(8), .DEPTH(MAX_PENDING)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    head_nxt  = head_r;
    ptr_nxt   = ptr_r;
    rem_nxt   = rem_r;
    hold_nxt  = hold_r;
    cmd_pop   = 1'b0;
    emit      = 1'b0;
    emit_item = '{out_byte: cmd.data_byte, last_of_run: 1'b1};
    wr_en     = 1'b0;
    wr_addr   = head_r;
    wr_data   = cmd.data_byte;
    rd_en     = 1'b0;
    rd_addr   = head_r;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.kind)
            CMD_EOS: begin
              cmd_pop  = 1'b1;
              cnt_nxt  = '0;
              head_nxt = '0;
            end
            CMD_BLANK: begin
              cmd_pop = 1'b1;
              if (cnt_r != CNT_W'(MAX_PENDING)) begin
                wr_en   = 1'b1;
                wr_addr = wrap_add(head_r, cnt_r);
                cnt_nxt = cnt_r + CNT_W'(1);
              end else begin
                rd_en     = 1'b1;
                hold_nxt  = cmd.data_byte;
                state_nxt = S_EVICT;
              end
            end
            CMD_EOL: begin
              if (free) begin
                cmd_pop  = 1'b1;
                emit     = 1'b1;
                cnt_nxt  = '0;
                head_nxt = '0;
              end
            end
            CMD_DATA: begin
              if (cnt_r == '0) begin
                if (free) begin
                  cmd_pop  = 1'b1;
                  emit     = 1'b1;
                  head_nxt = '0;
                end
              end else begin
                cmd_pop   = 1'b1;
                rd_en     = 1'b1;
                ptr_nxt   = wrap_add(head_r, CNT_W'(1));
                rem_nxt   = cnt_r;
                hold_nxt  = cmd.data_byte;
                state_nxt = S_EMIT;
              end
            end
          endcase
        end
      end
      S_EMIT: begin
        if (free) begin
          emit      = 1'b1;
          emit_item = '{out_byte: rd_data, last_of_run: 1'b0};
          if (rem_r == CNT_W'(1)) begin
            state_nxt = S_FINAL;
          end else begin
            rd_en   = 1'b1;
            rd_addr = ptr_r;
            ptr_nxt = wrap_add(ptr_r, CNT_W'(1));
            rem_nxt = rem_r - CNT_W'(1);
          end
        end
      end
      S_FINAL: begin
        if (free) begin
          emit      = 1'b1;
          emit_item = '{out_byte: hold_r, last_of_run: 1'b1};
          cnt_nxt   = '0;
          head_nxt  = '0;
          state_nxt = S_IDLE;
        end
      end
      S_EVICT: begin
        if (free) begin
          emit      = 1'b1;
          emit_item = '{out_byte: rd_data, last_of_run: 1'b1};
          // freed slot of the oldest blank takes the new one
          wr_en     = 1'b1;
          wr_addr   = head_r;
          wr_data   = hold_r;
          head_nxt  = wrap_add(head_r, CNT_W'(1));
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_nxt = out_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_nxt       = emit_item;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ptr_r  <= ptr_nxt;
    rem_r  <= rem_nxt;
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_PENDING)) else $error("blank count overflow");
  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_r < PTR_W'(MAX_PENDING)) else $error("store head out of range");
  a_emit_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> rem_r != '0) else $error("replay with nothing left");
  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EVICT |-> cnt_r == CNT_W'(MAX_PENDING)) else $error("evict while not full");

endmodule

// File: src/trailing_blank_stripper.sv
// Top level of the trailing blank stripper byte filter.
//
// Input beats carry an action bit and a data byte; output beats carry a byte
// and a last_of_run flag marking the final output caused by one input beat.
// Spaces and tabs are held in a 63-entry store. CR or LF drops held blanks
// and passes the line end. Any other byte replays the held blanks oldest
// first, then itself. End of stream drops held blanks silently. A blank
// arriving with the store full pushes the oldest held blank out at once.
// A two-entry command queue separates input classification from output
// sequencing, so input keeps flowing while the output side is busy.
// An input beat is written into the command queue; the output sequencer then
// drives each output beat from its output register. A blank is written into
// the store; an eviction reads the oldest blank, then emits it and stores the
// new blank. A byte that replays blanks emits them, one store read per cycle
// while out_stall is low, then itself; line ends and plain bytes need no read.
// Reset (rst_n low, synchronous) empties the queue and the store and drops
// any pending output. out_stall holds the output register; once the queue
// fills, in_stall rises.
module trailing_blank_stripper (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tbs_pkg::tbs_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output tbs_pkg::tbs_out_t out_data
);
  import tbs_pkg::*;

  logic     cmd_valid;
  tbs_cmd_t cmd;
  logic     cmd_pop;

  tbs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  tbs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
